// File: rtl/core/shc_pkg.sv
// SHA-512 core package: constants, round table, command/status structs.
// No dependencies.
package shc_pkg;

    localparam int LEN_BITS = 64;

    localparam logic [63:0] INIT_H [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam logic [63:0] ROUND_K [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [3:0] LEN_WORD   = 4'd14;
    localparam logic [3:0] LAST_WORD  = 4'd15;
    localparam logic [6:0] LAST_ROUND = 7'd79;

    typedef struct packed {
        logic       absorb;
        logic       pad_first;
        logic       zero_fill;
        logic       len_hi;
        logic       len_lo;
        logic       load;
        logic       round;
        logic       fold;
        logic       clear;
        logic [6:0] rnd;
    } t_cmd;

    typedef struct packed {
        logic       block_full;
        logic [3:0] widx;
    } t_status;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage

// File: rtl/core/shc_if.sv
// Valid/ready channel interfaces for the SHA-512 core.
// No dependencies.
interface shc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        message_end;
    modport source(output valid, data_word, byte_count, message_end, input ready);
    modport sink(input valid, data_word, byte_count, message_end, output ready);
endinterface

interface shc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
    modport source(output valid, digest_word, digest_index, digest_last, input ready);
    modport sink(input valid, digest_word, digest_index, digest_last, output ready);
endinterface

// File: rtl/core/shc_dp.sv
// SHA-512 datapath: byte packing, message schedule, rounds, chain, length.
// Depends on shc_pkg.
module shc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shc_pkg::t_cmd        i_cmd,
    input  logic [63:0]          i_data_word,
    input  logic [3:0]           i_byte_count,
    input  logic [2:0]           i_out_idx,
    output shc_pkg::t_status     o_status,
    output logic [63:0]          o_digest_word
);
    logic [63:0] r_h [0:7];
    logic [63:0] r_v [0:7];
    logic [63:0] r_w [0:15];
    logic [63:0] r_partial;
    logic [6:0]  r_fill;
    logic [shc_pkg::LEN_BITS-1:0] r_len;

    logic [3:0]   cnt;
    logic [3:0]   slot_sum;
    logic [63:0]  mask;
    logic [127:0] merged;
    logic [127:0] marked;
    logic [127:0] len128;
    logic         wrote;
    logic [63:0]  wr_word;
    logic         wr_en;
    logic [63:0]  sched;
    logic [63:0]  t1;
    logic [63:0]  t2;

    always_comb begin
        cnt      = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        slot_sum = {1'b0, r_fill[2:0]} + cnt;
        wrote    = slot_sum[3];
        mask     = ~({64{1'b1}} >> {cnt, 3'b000});
        merged   = {r_partial, 64'd0} | ({i_data_word & mask, 64'd0} >> {r_fill[2:0], 3'b000});
        marked   = {r_partial, 64'd0} | ({shc_pkg::PAD_BYTE, 120'd0} >> {r_fill[2:0], 3'b000});
        len128   = 128'(r_len) << 3;
        o_status.widx       = r_fill[6:3];
        o_status.block_full = wrote && (r_fill[6:3] == shc_pkg::LAST_WORD);
        wr_en   = 1'b0;
        wr_word = 64'd0;
        if (i_cmd.absorb) begin
            wr_en   = wrote;
            wr_word = merged[127:64];
        end else if (i_cmd.pad_first) begin
            wr_en   = 1'b1;
            wr_word = marked[127:64];
        end else if (i_cmd.zero_fill) begin
            wr_en   = 1'b1;
        end else if (i_cmd.len_hi) begin
            wr_en   = 1'b1;
            wr_word = len128[127:64];
        end else if (i_cmd.len_lo) begin
            wr_en   = 1'b1;
            wr_word = len128[63:0];
        end
        sched = (shc_pkg::rotr(r_w[14], 19) ^ shc_pkg::rotr(r_w[14], 61) ^ (r_w[14] >> 6))
              + r_w[9]
              + (shc_pkg::rotr(r_w[1], 1) ^ shc_pkg::rotr(r_w[1], 8) ^ (r_w[1] >> 7))
              + r_w[0];
        t1 = r_v[7]
           + (shc_pkg::rotr(r_v[4], 14) ^ shc_pkg::rotr(r_v[4], 18) ^ shc_pkg::rotr(r_v[4], 41))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + shc_pkg::ROUND_K[i_cmd.rnd] + r_w[0];
        t2 = (shc_pkg::rotr(r_v[0], 28) ^ shc_pkg::rotr(r_v[0], 34) ^ shc_pkg::rotr(r_v[0], 39))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    assign o_digest_word = r_h[i_out_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_h       <= shc_pkg::INIT_H;
            r_partial <= 64'd0;
            r_fill    <= 7'd0;
            r_len     <= '0;
        end else begin
            if (i_cmd.absorb) begin
                r_partial <= wrote ? merged[63:0] : merged[127:64];
                r_fill    <= r_fill + {3'd0, cnt};
                r_len     <= r_len + shc_pkg::LEN_BITS'(cnt);
            end else if (wr_en) begin
                r_partial <= 64'd0;
                r_fill    <= {r_fill[6:3] + 4'd1, 3'b000};
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= wr_word;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= sched;
        end
        if (i_cmd.load) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end
endmodule

// File: rtl/core/shc_ctrl.sv
// SHA-512 controller: sequences absorb, padding, 80 rounds and digest beats.
// Depends on shc_pkg.
module shc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_message_end,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_out_idx,
    input  shc_pkg::t_status i_status,
    output shc_pkg::t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_ROUND = 4'd2;
    localparam logic [3:0] S_FOLD  = 4'd3;
    localparam logic [3:0] S_PAD1  = 4'd4;
    localparam logic [3:0] S_PADZ  = 4'd5;
    localparam logic [3:0] S_LENH  = 4'd6;
    localparam logic [3:0] S_LENL  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic       r_last, n_last;
    logic       r_pad, n_pad;
    logic       r_final, n_final;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_idx   = r_cnt[2:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_pad   = r_pad;
        n_final = r_final;
        o_cmd   = '0;
        o_cmd.rnd = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.absorb = 1'b1;
                    n_last = i_message_end;
                    if (i_status.block_full) begin
                        n_state = S_LOAD;
                    end else if (i_message_end) begin
                        n_state = S_PAD1;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt   = 7'd0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == shc_pkg::LAST_ROUND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_cnt = 7'd0;
                if (r_final) begin
                    n_state = S_OUT;
                end else if (r_pad) begin
                    n_state = S_PADZ;
                end else if (r_last) begin
                    n_state = S_PAD1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD1: begin
                o_cmd.pad_first = 1'b1;
                n_pad   = 1'b1;
                n_state = (i_status.widx == shc_pkg::LAST_WORD) ? S_LOAD : S_PADZ;
            end
            S_PADZ: begin
                if (i_status.widx == shc_pkg::LEN_WORD) begin
                    n_state = S_LENH;
                end else begin
                    o_cmd.zero_fill = 1'b1;
                    if (i_status.widx == shc_pkg::LAST_WORD) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LENH: begin
                o_cmd.len_hi = 1'b1;
                n_state = S_LENL;
            end
            S_LENL: begin
                o_cmd.len_lo = 1'b1;
                n_final = 1'b1;
                n_state = S_LOAD;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_cnt = r_cnt + 7'd1;
                    if (r_cnt[2:0] == 3'd7) begin
                        o_cmd.clear = 1'b1;
                        n_last  = 1'b0;
                        n_pad   = 1'b0;
                        n_final = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 7'd0;
            r_last  <= 1'b0;
            r_pad   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_pad   <= n_pad;
            r_final <= n_final;
        end
    end
endmodule

// File: rtl/core/sha512_hash_core_top.sv
// SHA-512 hash core top level: controller plus datapath.
// Depends on shc_pkg, shc_in_if, shc_out_if, shc_ctrl, shc_dp.
//
// Input channel i_in: one beat per 64-bit big-endian message word, with a
// count of leading valid bytes (above 8 reads as 8) and an end-of-message
// flag. Output channel o_out: eight beats of digest, H0 first, index 0..7,
// digest_last on the eighth.
// A completed 128-byte block passes through load, 80 rounds and chain add,
// one round per cycle through the single round unit. The final word adds
// a pad or zero word for each remaining block word, a turn-around state
// before the two length words, and one or two block compressions; the first
// digest beat is offered in the cycle after the last chain add.
// The core holds one message item at a time: i_in.ready is high only while
// it waits for input.
// Reset loads the initial hash values and clears length and fill position.
// A stalled receiver holds the digest beat steady; nothing is lost.
module sha512_hash_core_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    shc_in_if.sink    i_in,
    shc_out_if.source o_out
);
    shc_pkg::t_cmd    cmd;
    shc_pkg::t_status status;
    logic [2:0]       out_idx;

    shc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_message_end (i_in.message_end),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_idx     (out_idx),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    shc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_word   (i_in.data_word),
        .i_byte_count  (i_in.byte_count),
        .i_out_idx     (out_idx),
        .o_status      (status),
        .o_digest_word (o_out.digest_word)
    );

    assign o_out.digest_index = out_idx;
    assign o_out.digest_last  = (out_idx == 3'd7);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while digest pending");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.digest_last) |=> (i_in.ready && !o_out.valid))
        else $error("core not idle after last digest beat");

    a_full_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && status.block_full) |=> !i_in.ready)
        else $error("input accepted during compression");
endmodule

// File: tb/sv/tb_sha512_digest_checker.sv
// Digest checker for the SHA-512 core: watches both channels, predicts digests.
// Depends on shc_pkg for the initial hash values and round constants.
module tb_sha512_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data_word,
    input  logic [3:0]  i_in_byte_count,
    input  logic        i_in_message_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_digest_word,
    input  logic [2:0]  i_out_digest_index,
    input  logic        i_out_digest_last,
    output int          o_err_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    logic [63:0]  hash_state [0:7];
    logic [63:0]  block_words [0:15];
    logic [63:0]  word_acc;
    logic [6:0]   fill_pos;
    logic [63:0]  byte_total;
    t_digest_beat digest_fifo [$];
    int           err_count;

    assign o_err_count = err_count;
    assign o_pending   = digest_fifo.size();

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic init_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = shc_pkg::INIT_H[i];
        word_acc   = '0;
        fill_pos   = '0;
        byte_total = '0;
    endtask

    task automatic compress();
        logic [63:0] w [0:79];
        logic [63:0] v [0:7];
        logic [63:0] t1, t2;
        for (int t = 0; t < 16; t++) w[t] = block_words[t];
        for (int t = 16; t < 80; t++)
            w[t] = (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
                 + (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 80; t++) begin
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shc_pkg::ROUND_K[t] + w[t];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic put_byte(input logic [7:0] b);
        logic [2:0] slot;
        slot = fill_pos[2:0];
        word_acc[(7 - slot) * 8 +: 8] = b;
        if (slot == 3'd7) begin
            block_words[fill_pos[6:3]] = word_acc;
            word_acc = '0;
        end
        fill_pos = fill_pos + 7'd1;
        if (fill_pos == 7'd0) compress();
    endtask

    task automatic absorb_beat(input logic [63:0] data, input logic [3:0] cnt,
                               input logic fin);
        int n;
        logic [63:0] len_lo, len_hi;
        t_digest_beat d;
        n = (cnt > 4'd8) ? 8 : int'(cnt);
        for (int i = 0; i < n; i++) begin
            put_byte(data[(7 - i) * 8 +: 8]);
            byte_total++;
        end
        if (fin) begin
            len_lo = byte_total << 3;
            len_hi = byte_total >> 61;
            put_byte(shc_pkg::PAD_BYTE);
            while (fill_pos != 7'd112) put_byte(8'h00);
            for (int i = 0; i < 8; i++) put_byte(len_hi[(7 - i) * 8 +: 8]);
            for (int i = 0; i < 8; i++) put_byte(len_lo[(7 - i) * 8 +: 8]);
            for (int i = 0; i < 8; i++) begin
                d.word  = hash_state[i];
                d.index = 3'(i);
                d.last  = (i == 7);
                digest_fifo.push_back(d);
            end
            init_hash();
        end
    endtask

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        err_count++;
    endtask

    initial begin
        err_count = 0;
        init_hash();
    end

    always @(posedge i_clk) begin
        t_digest_beat e;
        if (!i_rst_n) begin
            init_hash();
            digest_fifo.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                absorb_beat(i_in_data_word, i_in_byte_count, i_in_message_end);
            if (i_out_valid && i_out_ready) begin
                if (digest_fifo.size() == 0) begin
                    report("unexpected digest beat", i_out_digest_word, '0);
                end else begin
                    e = digest_fifo.pop_front();
                    if (i_out_digest_word !== e.word)
                        report("digest_word", i_out_digest_word, e.word);
                    if (i_out_digest_index !== e.index)
                        report("digest_index", 64'(i_out_digest_index), 64'(e.index));
                    if (i_out_digest_last !== e.last)
                        report("digest_last", 64'(i_out_digest_last), 64'(e.last));
                end
            end
        end
    end
endmodule

// File: tb/sv/tb_sha512_hash_core_top.sv
// Testbench top for sha512_hash_core_top: stimulus, output back-pressure, verdict.
// Depends on shc_pkg, shc_in_if, shc_out_if and tb_sha512_digest_checker.
module tb_sha512_hash_core_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   err_count, pending, idle_cycles, words_sent;
    bit   hold_off = 1'b0;
    bit   timed_out = 1'b0;

    shc_in_if  in_ch();
    shc_out_if out_ch();

    always #1 i_clk = ~i_clk;

    sha512_hash_core_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    tb_sha512_digest_checker checker_u (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_ch.valid),
        .i_in_ready         (in_ch.ready),
        .i_in_data_word     (in_ch.data_word),
        .i_in_byte_count    (in_ch.byte_count),
        .i_in_message_end   (in_ch.message_end),
        .i_out_valid        (out_ch.valid),
        .i_out_ready        (out_ch.ready),
        .i_out_digest_word  (out_ch.digest_word),
        .i_out_digest_index (out_ch.digest_index),
        .i_out_digest_last  (out_ch.digest_last),
        .o_err_count        (err_count),
        .o_pending          (pending)
    );

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.data_word   = '0;
        in_ch.byte_count  = '0;
        in_ch.message_end = 1'b0;
        out_ch.ready      = 1'b0;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // one beat, held until accepted
    task automatic send_beat(input logic [63:0] data, input logic [3:0] cnt,
                             input logic fin, input bit gaps);
        int g;
        g = gaps ? (($urandom_range(0, 3) == 0) ? gap_len() : 0) : 0;
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_word   <= data;
        in_ch.byte_count  <= cnt;
        in_ch.message_end <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // n full words, then a final word with cnt bytes
    task automatic send_message(input int n, input logic [3:0] cnt, input bit gaps);
        for (int i = 0; i < n; i++) send_beat(rand_word(), 4'd8, 1'b0, gaps);
        send_beat(rand_word(), cnt, 1'b1, gaps);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 9) < 7) ? 1'b1
                          : ($urandom_range(0, 19) == 0) ? 1'b0 : 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (!hold_off)
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1'b1;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int n;
        words_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat('0, 4'd0, 1'b1, 1'b0);
        send_beat(64'h6162638000000000, 4'd3, 1'b1, 1'b0);
        send_beat(64'hffffffffffffffff, 4'd8, 1'b1, 1'b0);
        send_beat(64'h0123456789abcdef, 4'd15, 1'b1, 1'b0);
        send_beat(64'h5555aaaa5555aaaa, 4'd9, 1'b0, 1'b0);
        send_beat(64'haaaa5555aaaa5555, 4'd2, 1'b0, 1'b0);
        send_beat('0, 4'd0, 1'b0, 1'b0);
        send_beat(64'hffffffffffffffff, 4'd7, 1'b1, 1'b0);
        send_message(13, 4'd7, 1'b0);
        send_message(13, 4'd8, 1'b0);
        drain();

        // receiver held off in its own process while messages keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < 3; i++) send_message(1, 4'd4, 1'b0);
        drain();

        while (words_sent < 420) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
            if ($urandom_range(0, 7) == 0) begin
                for (int i = 0; i < n; i++)
                    send_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b1);
                send_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b1, 1'b1);
            end else begin
                send_message(n, 4'($urandom_range(0, 8)), 1'b1);
            end
            if ($urandom_range(0, 9) == 0) drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (!timed_out) begin
            if (err_count == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
            $finish;
        end
    end
endmodule

// File: filelist.f
rtl/core/shc_pkg.sv
rtl/core/shc_if.sv
rtl/core/shc_dp.sv
rtl/core/shc_ctrl.sv
rtl/core/sha512_hash_core_top.sv
tb/sv/tb_sha512_digest_checker.sv
tb/sv/tb_sha512_hash_core_top.sv
